FILE: sv/rpa_pkg.sv
// types and constants shared by the page allocator files
`timescale 1ns / 1ps

package rpa_pkg;

  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned FREE_W     = 16;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [31:0] START_RESET = 32'h8002_0000;
  localparam logic [31:0] STOP_RESET  = 32'h8800_0000;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_ADDREF = 2'd2,
    ACT_INIT   = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    STAT_ALLOCATED   = 4'd0,
    STAT_OUT_OF_MEM  = 4'd1,
    STAT_RELEASED    = 4'd2,
    STAT_STILL_REF   = 4'd3,
    STAT_BAD_ADDR    = 4'd4,
    STAT_NOT_ALLOC   = 4'd5,
    STAT_REF_ADDED   = 4'd6,
    STAT_POOL_INIT   = 4'd7,
    STAT_SATURATED   = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP,
    S_UPDATE,
    S_INIT
  } state_t;

  localparam logic [CFG_IDX_W-1:0] REG_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP  = 1'd1;

endpackage

FILE: sv/rpa_if.sv
// valid/ready channel interfaces for requests and results
`timescale 1ns / 1ps

interface rpa_in_if;
  logic              valid;
  logic              ready;
  rpa_pkg::action_t  action;
  logic [31:0]       address;

  modport source (output valid, output action, output address, input ready);
  modport sink   (input valid, input action, input address, output ready);
endinterface

interface rpa_out_if;
  logic              valid;
  logic              ready;
  logic [31:0]       page_address;
  rpa_pkg::status_t  status;
  logic [15:0]       free_pages;

  modport source (output valid, output page_address, output status,
                  output free_pages, input ready);
  modport sink   (input valid, input page_address, input status,
                  input free_pages, output ready);
endinterface

FILE: sv/refcounted_page_allocator_top.sv
// page allocator: lifo free list and reference counts in two memories
//
//   channel   direction  transaction
//   in_if     sink       action, address
//   out_if    source     page_address, status, free_pages
//   cfg_*     write      region_start (index 0), region_stop (index 1)
//
// one request at a time; the result register frees the input side while it waits
// alloc: decode, stack read, count read-modify-write
// free and add reference: decode, count read-modify-write
// rejects and alloc on an empty pool: answered from decode
// init: one stack entry filled and one count cleared per cycle
// after reset the pool is empty; no clearing pass is needed
`timescale 1ns / 1ps

module refcounted_page_allocator_top #(
  parameter int unsigned NUM_PAGES   = 32768,
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  rpa_in_if.sink                       in_if,
  rpa_out_if.source                    out_if,
  input  logic                         cfg_we,
  input  logic [rpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                  cfg_data
);

  localparam int unsigned IDX_W   = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int unsigned DEPTH_W = $clog2(NUM_PAGES + 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  rpa_pkg::state_t  state_r, state_nxt;
  rpa_pkg::action_t act_r, act_nxt;
  logic [31:0]        addr_r, addr_nxt;
  logic [31:0]        start_r, stop_r;
  logic [32:0]        base_r;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [DEPTH_W-1:0] pool_r, pool_nxt;
  logic [DEPTH_W-1:0] sweep_r, sweep_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_page_r, out_page_nxt;
  rpa_pkg::status_t   out_status_r, out_status_nxt;
  logic [15:0]        out_free_r, out_free_nxt;

  logic [IDX_W-1:0]       stk_mem [NUM_PAGES];
  logic                   stk_we, stk_re;
  logic [IDX_W-1:0]       stk_waddr, stk_raddr, stk_wdata, stk_rdata_r;
  logic [COUNT_WIDTH-1:0] cnt_mem [NUM_PAGES];
  logic                   cnt_we, cnt_re;
  logic [IDX_W-1:0]       cnt_waddr, cnt_raddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata_r;

  logic               out_free;
  logic [32:0]        fr_off;
  logic               addr_ok;
  logic [IDX_W-1:0]   idx_dec;
  logic [33:0]        pool_span;
  logic [20:0]        span_pages;
  logic [DEPTH_W-1:0] pool_dec;
  logic [DEPTH_W-1:0] depth_m1;
  logic [32:0]        base_nxt;

  assign out_free = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == rpa_pkg::S_IDLE);

  assign out_if.valid        = out_valid_r;
  assign out_if.page_address = out_page_r;
  assign out_if.status       = out_status_r;
  assign out_if.free_pages   = out_free_r;

  assign base_nxt = ({1'b0, start_r} + 33'h0_0000_0FFF) & ~33'h0_0000_0FFF;

  // address check for free and add reference
  assign fr_off  = {1'b0, addr_r} - base_r;
  assign idx_dec = fr_off[rpa_pkg::PAGE_SHIFT +: IDX_W];
  assign addr_ok = (addr_r[rpa_pkg::PAGE_SHIFT-1:0] == '0) && ({1'b0, addr_r} >= base_r)
                   && (addr_r < stop_r)
                   && (32'(fr_off[32:rpa_pkg::PAGE_SHIFT]) < 32'(pool_r));

  // pool size for init
  assign pool_span  = {2'b00, stop_r} - {1'b0, base_r};
  assign span_pages = pool_span[32:rpa_pkg::PAGE_SHIFT];
  assign pool_dec   = pool_span[33] ? '0 :
                      (32'(span_pages) > 32'(NUM_PAGES)) ? DEPTH_W'(NUM_PAGES) :
                      DEPTH_W'(span_pages);

  assign depth_m1 = depth_r - 1'b1;

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    addr_nxt       = addr_r;
    depth_nxt      = depth_r;
    pool_nxt       = pool_r;
    sweep_nxt      = sweep_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_page_nxt   = out_page_r;
    out_status_nxt = out_status_r;
    out_free_nxt   = out_free_r;
    stk_we    = 1'b0;
    stk_waddr = '0;
    stk_wdata = '0;
    stk_re    = 1'b0;
    stk_raddr = depth_m1[IDX_W-1:0];
    cnt_we    = 1'b0;
    cnt_waddr = idx_r;
    cnt_wdata = '0;
    cnt_re    = 1'b0;
    cnt_raddr = idx_dec;

    unique case (state_r)
      rpa_pkg::S_IDLE: begin
        if (in_if.valid) begin
          act_nxt   = in_if.action;
          addr_nxt  = in_if.address;
          state_nxt = rpa_pkg::S_DECODE;
        end
      end

      rpa_pkg::S_DECODE: begin
        unique case (act_r)
          rpa_pkg::ACT_ALLOC: begin
            if (depth_r == '0) begin
              if (out_free) begin
                out_valid_nxt  = 1'b1;
                out_page_nxt   = '0;
                out_status_nxt = rpa_pkg::STAT_OUT_OF_MEM;
                out_free_nxt   = 16'(depth_r);
                state_nxt      = rpa_pkg::S_IDLE;
              end
            end else begin
              stk_re    = 1'b1;
              depth_nxt = depth_m1;
              state_nxt = rpa_pkg::S_POP;
            end
          end
          rpa_pkg::ACT_FREE, rpa_pkg::ACT_ADDREF: begin
            if (addr_ok) begin
              cnt_re    = 1'b1;
              idx_nxt   = idx_dec;
              state_nxt = rpa_pkg::S_UPDATE;
            end else if (out_free) begin
              out_valid_nxt  = 1'b1;
              out_page_nxt   = '0;
              out_status_nxt = rpa_pkg::STAT_BAD_ADDR;
              out_free_nxt   = 16'(depth_r);
              state_nxt      = rpa_pkg::S_IDLE;
            end
          end
          rpa_pkg::ACT_INIT: begin
            pool_nxt  = pool_dec;
            depth_nxt = pool_dec;
            sweep_nxt = '0;
            state_nxt = rpa_pkg::S_INIT;
          end
          default: state_nxt = rpa_pkg::S_IDLE;
        endcase
      end

      rpa_pkg::S_POP: begin
        cnt_re    = 1'b1;
        cnt_raddr = stk_rdata_r;
        idx_nxt   = stk_rdata_r;
        state_nxt = rpa_pkg::S_UPDATE;
      end

      rpa_pkg::S_UPDATE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_page_nxt  = '0;
          state_nxt     = rpa_pkg::S_IDLE;
          unique case (act_r)
            rpa_pkg::ACT_ALLOC: begin
              cnt_we         = 1'b1;
              cnt_wdata      = (cnt_rdata_r == CNT_MAX) ? cnt_rdata_r : cnt_rdata_r + 1'b1;
              out_page_nxt   = base_r[31:0] + 32'({idx_r, {rpa_pkg::PAGE_SHIFT{1'b0}}});
              out_status_nxt = rpa_pkg::STAT_ALLOCATED;
            end
            rpa_pkg::ACT_FREE: begin
              if (cnt_rdata_r == '0) begin
                out_status_nxt = rpa_pkg::STAT_NOT_ALLOC;
              end else begin
                cnt_we    = 1'b1;
                cnt_wdata = cnt_rdata_r - 1'b1;
                if (cnt_rdata_r == COUNT_WIDTH'(1)) begin
                  out_status_nxt = rpa_pkg::STAT_RELEASED;
                  if (32'(depth_r) < 32'(NUM_PAGES)) begin
                    stk_we    = 1'b1;
                    stk_waddr = depth_r[IDX_W-1:0];
                    stk_wdata = idx_r;
                    depth_nxt = depth_r + 1'b1;
                  end
                end else begin
                  out_status_nxt = rpa_pkg::STAT_STILL_REF;
                end
              end
            end
            rpa_pkg::ACT_ADDREF: begin
              if (cnt_rdata_r == '0) begin
                out_status_nxt = rpa_pkg::STAT_NOT_ALLOC;
              end else if (cnt_rdata_r == CNT_MAX) begin
                out_status_nxt = rpa_pkg::STAT_SATURATED;
              end else begin
                cnt_we         = 1'b1;
                cnt_wdata      = cnt_rdata_r + 1'b1;
                out_status_nxt = rpa_pkg::STAT_REF_ADDED;
              end
            end
            default: out_status_nxt = rpa_pkg::STAT_POOL_INIT;
          endcase
          out_free_nxt = 16'(depth_nxt);
        end
      end

      rpa_pkg::S_INIT: begin
        if (sweep_r != pool_r) begin
          stk_we    = 1'b1;
          stk_waddr = sweep_r[IDX_W-1:0];
          stk_wdata = sweep_r[IDX_W-1:0];
          cnt_we    = 1'b1;
          cnt_waddr = sweep_r[IDX_W-1:0];
          cnt_wdata = '0;
          sweep_nxt = sweep_r + 1'b1;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_page_nxt   = '0;
          out_status_nxt = rpa_pkg::STAT_POOL_INIT;
          out_free_nxt   = 16'(depth_r);
          state_nxt      = rpa_pkg::S_IDLE;
        end
      end

      default: state_nxt = rpa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpa_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      depth_r     <= '0;
      pool_r      <= '0;
      sweep_r     <= '0;
      start_r     <= rpa_pkg::START_RESET;
      stop_r      <= rpa_pkg::STOP_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      depth_r     <= depth_nxt;
      pool_r      <= pool_nxt;
      sweep_r     <= sweep_nxt;
      if (cfg_we && cfg_index == rpa_pkg::REG_START) begin
        start_r <= cfg_data;
      end
      if (cfg_we && cfg_index == rpa_pkg::REG_STOP) begin
        stop_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    base_r       <= base_nxt;
    act_r        <= act_nxt;
    addr_r       <= addr_nxt;
    idx_r        <= idx_nxt;
    out_page_r   <= out_page_nxt;
    out_status_r <= out_status_nxt;
    out_free_r   <= out_free_nxt;
  end

  // free list memory
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata_r <= stk_mem[stk_raddr];
    end
  end

  // reference count memory
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rdata_r <= cnt_mem[cnt_raddr];
    end
  end

endmodule

FILE: bench/refcounted_page_allocator_top_test.sv
// self-checking testbench for the page allocator: random and directed requests, predicted results
`timescale 1ns / 1ps

module refcounted_page_allocator_top_test;

  localparam int unsigned POOL_LIMIT   = 32768;
  localparam int unsigned COUNT_BITS   = 8;
  localparam int unsigned COUNT_TOP    = (1 << COUNT_BITS) - 1;
  localparam int unsigned IDX_W        = $clog2(POOL_LIMIT);
  localparam int unsigned RANDOM_ITEMS = 1625;
  localparam int unsigned LIMIT_CYCLES = 1000000;

  typedef struct packed {
    logic [31:0]      page;
    rpa_pkg::status_t status;
    logic [15:0]      free;
  } result_t;

  class page_pool_scoreboard;
    logic [31:0]           region_start;
    logic [31:0]           region_stop;
    logic [IDX_W-1:0]      free_list [POOL_LIMIT];
    logic [COUNT_BITS-1:0] counts [POOL_LIMIT];
    logic [15:0]           depth;
    logic [15:0]           pool_pages;
    int unsigned           held [$];
    result_t               awaited [$];
    int unsigned           errors;

    function new();
      region_start = rpa_pkg::START_RESET;
      region_stop  = rpa_pkg::STOP_RESET;
      depth        = '0;
      pool_pages   = '0;
      errors       = 0;
      foreach (counts[i]) counts[i] = '0;
      foreach (free_list[i]) free_list[i] = '0;
    endfunction

    function void set_region(logic [rpa_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
      if (idx == rpa_pkg::REG_START) region_start = val;
      else region_stop = val;
    endfunction

    function logic [32:0] base();
      return ({1'b0, region_start} + 33'hFFF) & ~33'hFFF;
    endfunction

    function logic [31:0] page_address(int unsigned idx);
      logic [32:0] a;
      a = base() + (33'(idx) << rpa_pkg::PAGE_SHIFT);
      return a[31:0];
    endfunction

    // pages that an init with the current region would build
    function int unsigned sized_pool();
      logic [32:0] b;
      logic [32:0] n;
      b = base();
      n = '0;
      if (b + 33'h1000 <= {1'b0, region_stop})
        n = ({1'b0, region_stop} - b) >> rpa_pkg::PAGE_SHIFT;
      if (n > POOL_LIMIT) n = 33'(POOL_LIMIT);
      return n[31:0];
    endfunction

    function bit locate(logic [31:0] addr, output int unsigned idx);
      logic [32:0] b;
      logic [32:0] off;
      b   = base();
      idx = 0;
      if (addr[rpa_pkg::PAGE_SHIFT-1:0] != '0) return 1'b0;
      if ({1'b0, addr} < b || addr >= region_stop) return 1'b0;
      off = ({1'b0, addr} - b) >> rpa_pkg::PAGE_SHIFT;
      if (off >= pool_pages) return 1'b0;
      idx = off[31:0];
      return 1'b1;
    endfunction

    function void note_request(rpa_pkg::action_t act, logic [31:0] addr);
      result_t     r;
      int unsigned idx;
      int          pos;
      r.page   = '0;
      r.status = rpa_pkg::STAT_POOL_INIT;
      pos      = -1;
      case (act)
        rpa_pkg::ACT_ALLOC: begin
          if (depth == 0) begin
            r.status = rpa_pkg::STAT_OUT_OF_MEM;
          end else begin
            depth = depth - 1'b1;
            idx   = 32'(free_list[depth]);
            if (counts[idx] != COUNT_TOP) counts[idx] = counts[idx] + 1'b1;
            held.push_back(idx);
            r.page   = page_address(idx);
            r.status = rpa_pkg::STAT_ALLOCATED;
          end
        end
        rpa_pkg::ACT_FREE: begin
          if (!locate(addr, idx)) begin
            r.status = rpa_pkg::STAT_BAD_ADDR;
          end else if (counts[idx] == 0) begin
            r.status = rpa_pkg::STAT_NOT_ALLOC;
          end else begin
            counts[idx] = counts[idx] - 1'b1;
            if (counts[idx] != 0) begin
              r.status = rpa_pkg::STAT_STILL_REF;
            end else begin
              if (depth < POOL_LIMIT) begin
                free_list[depth] = IDX_W'(idx);
                depth = depth + 1'b1;
              end
              foreach (held[k]) if (held[k] == idx) pos = k;
              if (pos >= 0) held.delete(pos);
              r.status = rpa_pkg::STAT_RELEASED;
            end
          end
        end
        rpa_pkg::ACT_ADDREF: begin
          if (!locate(addr, idx)) r.status = rpa_pkg::STAT_BAD_ADDR;
          else if (counts[idx] == 0) r.status = rpa_pkg::STAT_NOT_ALLOC;
          else if (counts[idx] >= COUNT_TOP) r.status = rpa_pkg::STAT_SATURATED;
          else begin
            counts[idx] = counts[idx] + 1'b1;
            r.status = rpa_pkg::STAT_REF_ADDED;
          end
        end
        default: begin
          pool_pages = 16'(sized_pool());
          foreach (counts[i]) counts[i] = '0;
          for (int i = 0; i < pool_pages; i++) free_list[i] = IDX_W'(i);
          depth = pool_pages;
          held.delete();
        end
      endcase
      r.free = depth;
      awaited.push_back(r);
    endfunction

    function void check_result(logic [31:0] page, rpa_pkg::status_t st, logic [15:0] free);
      result_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: page=%h status=%0d free=%0d", page, st, free);
        return;
      end
      want = awaited.pop_front();
      if (want.page !== page || want.status !== st || want.free !== free) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp page=%h status=%0d free=%0d, got page=%h status=%0d free=%0d",
                   want.page, want.status, want.free, page, st, free);
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [rpa_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0]                   cfg_data;

  rpa_in_if  in_if ();
  rpa_out_if out_if ();

  page_pool_scoreboard sb;

  int unsigned burst_left = 1;
  int unsigned sent = 0;
  int unsigned hammers = 0;
  int unsigned cycle_count = 0;

  refcounted_page_allocator_top #(
    .NUM_PAGES  (POOL_LIMIT),
    .COUNT_WIDTH(COUNT_BITS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .out_if   (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: checks transactions and stalls on its own pattern
  int unsigned results_seen = 0;
  int unsigned hold_left = 0;
  int unsigned mode = 0;
  int unsigned mode_left = 0;
  logic [7:0]  pattern = 8'hA5;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        sb.check_result(out_if.page_address, out_if.status, out_if.free_pages);
        results_seen++;
        if (results_seen == 200 || results_seen == 1000) hold_left = 500;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 300);
          pattern   = 8'($urandom_range(1, 255));
        end
        mode_left--;
        pattern = {pattern[6:0], pattern[7]};
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= 1'($urandom_range(0, 1));
          2: out_if.ready <= ($urandom_range(0, 7) != 0);
          default: out_if.ready <= pattern[0];
        endcase
      end
    end
  end

  task automatic offer(rpa_pkg::action_t act, logic [31:0] addr);
    int unsigned gap;
    in_if.valid   <= 1'b1;
    in_if.action  <= act;
    in_if.address <= addr;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(act, addr);
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 10);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // sender pause until every result is back and the block is idle
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_region(bit do_start, logic [31:0] s, bit do_stop, logic [31:0] e);
    if (do_start) begin
      cfg_we    <= 1'b1;
      cfg_index <= rpa_pkg::REG_START;
      cfg_data  <= s;
      @(posedge clk);
      sb.set_region(rpa_pkg::REG_START, s);
    end
    if (do_stop) begin
      cfg_we    <= 1'b1;
      cfg_index <= rpa_pkg::REG_STOP;
      cfg_data  <= e;
      @(posedge clk);
      sb.set_region(rpa_pkg::REG_STOP, e);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic choose_region(int unsigned phase, output logic [31:0] s,
                               output logic [31:0] e);
    int unsigned n;
    logic [31:0] b;
    n = $urandom_range(1, 48);
    s = $urandom_range(0, 32'hFFF0_0000);
    if ($urandom_range(0, 1)) s[11:0] = '0;
    b = (s + 32'hFFF) & ~32'hFFF;
    e = b + (n << rpa_pkg::PAGE_SHIFT) + $urandom_range(0, 4095);
    if (phase == 2) begin
      s = $urandom() & 32'h3FFF_FFFF;
      e = s + ($urandom_range(20000, 40000) << rpa_pkg::PAGE_SHIFT);
    end else if (phase > 2) begin
      case ($urandom_range(0, 15))
        0: begin
          s = '0;
          e = '0;
        end
        1: begin
          s = '1;
          e = '1;
        end
        2: e = s;
        3: e = b + $urandom_range(0, 4095);
        4: begin
          s = 32'h0 - (n << rpa_pkg::PAGE_SHIFT);
          e = '1;
        end
        default: ;
      endcase
    end
  endtask

  function automatic logic [31:0] stray_address();
    logic [31:0] b;
    b = sb.page_address(0);
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return b + ($urandom_range(0, sb.pool_pages + 3) << rpa_pkg::PAGE_SHIFT);
      2: return b + ($urandom_range(0, 64) << rpa_pkg::PAGE_SHIFT) + $urandom_range(1, 4095);
      default: return b - ($urandom_range(1, 4) << rpa_pkg::PAGE_SHIFT);
    endcase
  endfunction

  task automatic step_random();
    int unsigned k;
    logic [31:0] a;
    k = $urandom_range(0, 99);
    if (sb.held.size() != 0) a = sb.page_address(sb.held[$urandom_range(0, sb.held.size() - 1)]);
    else a = '0;
    if (sb.held.size() != 0 && (hammers == 0 || (k == 0 && hammers < 3))) begin
      // drive one page's count into saturation, then back off
      hammers++;
      repeat (COUNT_TOP + 3) offer(rpa_pkg::ACT_ADDREF, a);
      repeat (3) offer(rpa_pkg::ACT_FREE, a);
      sent += COUNT_TOP + 6;
    end else begin
      if (sb.held.size() == 0 || k < 30) offer(rpa_pkg::ACT_ALLOC, $urandom());
      else if (k < 58) offer(rpa_pkg::ACT_FREE, a);
      else if (k < 74) offer(rpa_pkg::ACT_ADDREF, a);
      else if (k < 95) offer(k[0] ? rpa_pkg::ACT_FREE : rpa_pkg::ACT_ADDREF, stray_address());
      else if (k < 98 && sb.sized_pool() <= 256) offer(rpa_pkg::ACT_INIT, $urandom());
      else offer(rpa_pkg::ACT_ALLOC, $urandom());
      sent++;
    end
  endtask

  initial begin
    logic [31:0] s;
    logic [31:0] e;
    int unsigned phase;
    sb = new();
    in_if.valid   <= 1'b0;
    in_if.action  <= rpa_pkg::ACT_ALLOC;
    in_if.address <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= rpa_pkg::REG_START;
    cfg_data      <= '0;
    rst_n         <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // empty pool straight after reset
    offer(rpa_pkg::ACT_ALLOC, '0);
    offer(rpa_pkg::ACT_FREE, rpa_pkg::START_RESET);
    offer(rpa_pkg::ACT_ADDREF, 32'hFFFF_FFFF);
    settle();

    // four pages from an unaligned start
    program_region(1'b1, 32'h0000_1001, 1'b1, 32'h0000_6000);
    offer(rpa_pkg::ACT_INIT, 32'hFFFF_FFFF);
    offer(rpa_pkg::ACT_ALLOC, '0);
    offer(rpa_pkg::ACT_ALLOC, '0);
    offer(rpa_pkg::ACT_ADDREF, 32'h0000_5000);
    offer(rpa_pkg::ACT_FREE, 32'h0000_5000);
    offer(rpa_pkg::ACT_FREE, 32'h0000_5000);
    offer(rpa_pkg::ACT_FREE, 32'h0000_5000);
    offer(rpa_pkg::ACT_ADDREF, 32'h0000_5000);
    offer(rpa_pkg::ACT_FREE, 32'h0000_4001);
    offer(rpa_pkg::ACT_FREE, 32'h0000_1000);
    offer(rpa_pkg::ACT_ADDREF, 32'h0000_6000);
    offer(rpa_pkg::ACT_ADDREF, 32'h0000_0000);
    repeat (4) offer(rpa_pkg::ACT_ALLOC, '0);
    settle();

    // remap without init, the pool size stays
    program_region(1'b1, 32'h0000_0000, 1'b0, '0);
    offer(rpa_pkg::ACT_FREE, 32'h0000_3000);
    settle();

    // start too high to round up
    program_region(1'b1, 32'hFFFF_F001, 1'b1, 32'hFFFF_FFFF);
    offer(rpa_pkg::ACT_INIT, '0);
    offer(rpa_pkg::ACT_ALLOC, '0);
    settle();

    // whole address space, pool capped
    program_region(1'b1, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF);
    offer(rpa_pkg::ACT_INIT, '0);
    offer(rpa_pkg::ACT_ALLOC, '0);
    offer(rpa_pkg::ACT_FREE, 32'h07FF_F000);

    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      if (phase > 2 && $urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 1)) program_region(1'b1, $urandom(), 1'b0, '0);
        else program_region(1'b0, '0, 1'b1, $urandom());
      end else begin
        choose_region(phase, s, e);
        program_region(1'b1, s, 1'b1, e);
        offer(rpa_pkg::ACT_INIT, $urandom());
        sent++;
      end
      repeat ($urandom_range(20, 100)) step_random();
      phase++;
    end

    settle();
    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: refcounted_page_allocator_top.f
sv/rpa_pkg.sv
sv/rpa_if.sv
sv/refcounted_page_allocator_top.sv
bench/refcounted_page_allocator_top_test.sv
